[sv/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/tpc_pkg.sv]
// package: constants, permutation table and table helpers for the canonical-form pipeline
package tpc_pkg;

  localparam int unsigned MAX_INPUTS = 4;
  localparam int unsigned TABLE_VARS = 4;
  localparam int unsigned N_LIM      = (MAX_INPUTS < TABLE_VARS) ? MAX_INPUTS : TABLE_VARS;
  localparam int unsigned TBL_W      = 16;
  localparam int unsigned NUM_W      = 3;
  localparam int unsigned NUM_PERMS  = 24;
  localparam int unsigned GRP        = 4;
  localparam int unsigned NUM_GRPS   = NUM_PERMS / GRP;

  typedef logic [TBL_W-1:0] tbl_t;
  typedef logic [NUM_W-1:0] num_t;

  // each entry packs p0..p3, p0 in bits 7:6
  localparam logic [7:0] PERM_TBL [NUM_PERMS] = '{
    8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39,
    8'h4B, 8'h4E, 8'h63, 8'h6C, 8'h72, 8'h78,
    8'h87, 8'h8D, 8'h93, 8'h9C, 8'hB1, 8'hB4,
    8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4
  };

  function automatic num_t sat_num(num_t req);
    num_t lim;
    lim = num_t'(N_LIM);
    return (req > lim) ? lim : req;
  endfunction

  function automatic tbl_t row_mask(num_t nv);
    tbl_t m;
    m = '0;
    for (int r = 0; r < TBL_W; r++) begin
      if (r < (1 << nv)) m[r] = 1'b1;
    end
    return m;
  endfunction

  // true when the permutation leaves every variable at or above nv in place
  function automatic logic perm_fits(logic [7:0] pc, int unsigned nv);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < TABLE_VARS; i++) begin
      if (i >= nv && pc[7-2*i -: 2] != 2'(i)) ok = 1'b0;
    end
    return ok;
  endfunction

  // permuted table for a fixed variable count; a pure rewiring of bits
  function automatic tbl_t permute_tbl(tbl_t tbl, int unsigned nv, logic [7:0] pc);
    tbl_t res;
    int unsigned rows;
    int unsigned src;
    res  = '0;
    rows = 1 << nv;
    for (int unsigned idx = 0; idx < TBL_W; idx++) begin
      if (idx < rows) begin
        src = 0;
        for (int unsigned i = 0; i < TABLE_VARS; i++) begin
          if (i < nv) begin
            src = src | (((idx >> (nv - 1 - i)) & 1) << (nv - 1 - pc[7-2*i -: 2]));
          end
        end
        res[rows-1-idx] = tbl[rows-1-src];
      end
    end
    return res;
  endfunction

  function automatic tbl_t min2(tbl_t a, tbl_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

[sv/tpc_cands.sv]
// candidate stage: all permuted tables of one word, registered
module tpc_cands (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_in,
  input  tpc_pkg::num_t             num_in,
  input  tpc_pkg::tbl_t             tbl_in,
  output logic                      vld_out,
  output tpc_pkg::tbl_t             cand_out [tpc_pkg::NUM_PERMS]
);
  import tpc_pkg::*;

  logic vld_r;
  tbl_t cand_r   [NUM_PERMS];
  tbl_t cand_nxt [NUM_PERMS];

  for (genvar k = 0; k < NUM_PERMS; k++) begin : g_perm
    tbl_t c2, c3, c4;
    assign c2 = perm_fits(PERM_TBL[k], 2) ? permute_tbl(tbl_in, 2, PERM_TBL[k]) : tbl_in;
    assign c3 = perm_fits(PERM_TBL[k], 3) ? permute_tbl(tbl_in, 3, PERM_TBL[k]) : tbl_in;
    assign c4 = perm_fits(PERM_TBL[k], 4) ? permute_tbl(tbl_in, 4, PERM_TBL[k]) : tbl_in;
    always_comb begin
      case (num_in)
        3'd2:    cand_nxt[k] = c2;
        3'd3:    cand_nxt[k] = c3;
        3'd4:    cand_nxt[k] = c4;
        default: cand_nxt[k] = tbl_in;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cand_r <= cand_nxt;
    end
  end

  assign vld_out  = vld_r;
  assign cand_out = cand_r;
endmodule

[sv/tpc_min_grp.sv]
// first minimum stage: each group of four candidates reduced to one, registered
module tpc_min_grp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      vld_in,
  input  tpc_pkg::tbl_t             cand_in [tpc_pkg::NUM_PERMS],
  output logic                      vld_out,
  output tpc_pkg::tbl_t             grp_out [tpc_pkg::NUM_GRPS]
);
  import tpc_pkg::*;

  logic vld_r;
  tbl_t grp_r   [NUM_GRPS];
  tbl_t grp_nxt [NUM_GRPS];

  always_comb begin
    for (int g = 0; g < NUM_GRPS; g++) begin
      grp_nxt[g] = min2(min2(cand_in[GRP*g],   cand_in[GRP*g+1]),
                        min2(cand_in[GRP*g+2], cand_in[GRP*g+3]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp_r <= grp_nxt;
    end
  end

  assign vld_out = vld_r;
  assign grp_out = grp_r;
endmodule

[sv/truth_table_perm_canonical.sv]
// top level: permutation-canonical form of a truth table of up to four inputs
// Pipeline of four register stages (input, candidate tables, group minimum,
// output): a word's result passes through them in that order and sits in the
// output register until it is taken, and a new word is taken every cycle
// while no finished result waits stalled. The throughput is
// set by the single shared stall: the whole pipeline holds while a finished
// result waits at the output register, and in_stall follows out_stall in that
// case. num_inputs above four saturates to four; table bits at and above 2^n
// are ignored and come out as zero.
module truth_table_perm_canonical (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpc_pkg::num_t        in_num_inputs,
  input  tpc_pkg::tbl_t        in_truth_table,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tpc_pkg::tbl_t        out_canonical_table
);
  import tpc_pkg::*;

  logic en;
  logic vld0_r;
  num_t num0_r;
  tbl_t tbl0_r;
  logic vld1;
  tbl_t cand1 [NUM_PERMS];
  logic vld2;
  tbl_t grp2 [NUM_GRPS];
  logic out_vld_r;
  tbl_t out_tbl_r;
  tbl_t out_tbl_nxt;
  num_t num_sat;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;
  assign num_sat  = sat_num(in_num_inputs);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num0_r <= num_sat;
      tbl0_r <= in_truth_table & row_mask(num_sat);
    end
  end

  tpc_cands u_cands (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (vld0_r),
    .num_in   (num0_r),
    .tbl_in   (tbl0_r),
    .vld_out  (vld1),
    .cand_out (cand1)
  );

  tpc_min_grp u_min_grp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_in  (vld1),
    .cand_in (cand1),
    .vld_out (vld2),
    .grp_out (grp2)
  );

  // final minimum over the group results
  always_comb begin
    out_tbl_nxt = grp2[0];
    for (int g = 1; g < NUM_GRPS; g++) begin
      out_tbl_nxt = min2(out_tbl_nxt, grp2[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tbl_r <= out_tbl_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_canonical_table = out_tbl_r;
endmodule

[sv/tpc_checker.sv]
// port-level checker for the canonical-form block, with its bind
`include "assert_macros.svh"

module tpc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input tpc_pkg::num_t in_num_inputs,
  input tpc_pkg::tbl_t in_truth_table,
  input logic          out_valid,
  input logic          out_stall,
  input tpc_pkg::tbl_t out_canonical_table
);
  import tpc_pkg::*;

  logic acc_zero;
  logic acc_any;

  assign acc_zero = in_valid && !in_stall && (in_num_inputs == '0);
  assign acc_any  = in_valid && !in_stall;

  // held result stays put
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_canonical_table))

  // input only stalls behind a waiting result
  `ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // a word moving freely through the input, candidate, group-minimum and output registers shows up at the output
  `ASSERT_IMP(a_latency, clk, rst_n, $past(acc_any, 4) && !$past(in_stall, 3) && !$past(in_stall, 2) && !$past(in_stall, 1), out_valid)

  // zero inputs: only row 0 survives
  `ASSERT_IMP(a_zero_vars, clk, rst_n, $past(acc_zero, 4) && !$past(in_stall, 3) && !$past(in_stall, 2) && !$past(in_stall, 1), out_canonical_table == {15'b0, $past(in_truth_table[0], 4)})

endmodule

bind truth_table_perm_canonical tpc_checker u_tpc_checker (.*);

[tb/tb_truth_table_perm_canonical.sv]
// testbench for truth_table_perm_canonical: directed and random tables checked against a permutation search
module tb_truth_table_perm_canonical;
  import tpc_pkg::*;

  class canon_tracker;
    tbl_t canon_due[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // smallest table over all permutations of the used variables
    function tbl_t canon_of(num_t req, tbl_t tbl);
      int unsigned n;
      int unsigned rows;
      int unsigned total;
      int unsigned rest;
      int unsigned src;
      int unsigned used;
      int unsigned perm[4];
      tbl_t masked;
      tbl_t best;
      tbl_t cand;
      bit ok;
      n = (req > N_LIM) ? N_LIM : req;
      rows = 1 << n;
      masked = (rows >= 16) ? tbl : (tbl & ((16'd1 << rows) - 16'd1));
      if (n <= 1) return masked;
      best = masked;
      total = 1;
      for (int unsigned i = 0; i < n; i++) total = total * n;
      for (int unsigned code = 0; code < total; code++) begin
        rest = code;
        used = 0;
        ok = 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
          perm[i] = rest % n;
          rest = rest / n;
          if (used & (1 << perm[i])) ok = 1'b0;
          used = used | (1 << perm[i]);
        end
        if (ok) begin
          cand = '0;
          for (int unsigned idx = 0; idx < rows; idx++) begin
            src = 0;
            for (int unsigned i = 0; i < n; i++) begin
              src = src | (((idx >> (n - 1 - i)) & 1) << (n - 1 - perm[i]));
            end
            cand[rows-1-idx] = masked[rows-1-src];
          end
          if (cand < best) best = cand;
        end
      end
      return best;
    endfunction

    function void note_table(num_t num, tbl_t tbl);
      canon_due = {canon_due, canon_of(num, tbl)};
    endfunction

    function void check_canon(tbl_t got);
      tbl_t want;
      if (canon_due.size() == 0) begin
        $error("canonical_table: expected none, actual %h", got);
        fails++;
        return;
      end
      want = canon_due.pop_front();
      if (got !== want) begin
        $error("canonical_table: expected %h, actual %h", want, got);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return canon_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  num_t in_num_inputs = '0;
  tbl_t in_truth_table = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tbl_t out_canonical_table;

  canon_tracker tracker;
  int unsigned idle_pct = 20;
  bit hold_req = 1'b0;

  truth_table_perm_canonical uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_num_inputs       (in_num_inputs),
    .in_truth_table      (in_truth_table),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_canonical_table (out_canonical_table)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3200000;
    $display("FAIL");
    $finish;
  end

  task automatic send_table(input num_t num, input tbl_t tbl);
    in_valid <= 1'b1;
    in_num_inputs <= num;
    in_truth_table <= tbl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_table(num, tbl);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // receiver: random stall bursts, one long hold on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      for (int c = 0; c < 150; c++) @(posedge clk);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_canon(out_canonical_table);
  end

  initial begin
    num_t num;
    int unsigned drain;
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < 8; n++) begin
      send_table(num_t'(n), 16'h0000);
      send_table(num_t'(n), 16'hFFFF);
    end
    send_table(3'd4, 16'h8000);
    send_table(3'd4, 16'h0001);
    send_table(3'd4, 16'h6996);
    send_table(3'd3, 16'h5A17);
    send_table(3'd2, 16'hFFF2);
    send_table(3'd1, 16'hABC1);
    send_table(3'd7, 16'h0F35);
    send_table(3'd5, 16'h1248);

    for (int k = 0; k < 1600; k++) begin
      if (k % 200 == 0) idle_pct = (k >= 1400) ? 0 : $urandom_range(0, 40);
      if (k == 300) hold_req = 1'b1;
      if (k == 700) wait_drained();
      if ($urandom_range(0, 9) < 7) num = num_t'($urandom_range(2, 4));
      else num = num_t'($urandom_range(0, 7));
      send_table(num, tbl_t'($urandom));
    end
    in_valid <= 1'b0;

    drain = 0;
    while (tracker.pending() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (16) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("canonical_table: %0d expected words never arrived", tracker.pending());
      tracker.fails++;
    end
    if (tracker.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
